// ----- hw/rtl/rgb2p010_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb2p010_pkg: shared types and constants
// format codes, coefficient sets and helper functions for the converter
// ----------------------------------------------------------------------------
package rgb2p010_pkg;

  localparam logic [1:0] FMT_R210 = 2'd0;
  localparam logic [1:0] FMT_R10B = 2'd1;
  localparam logic [1:0] FMT_R10L = 2'd2;
  localparam logic [1:0] FMT_C12  = 2'd3;

  localparam logic CFG_PIXEL_FORMAT = 1'b0;
  localparam logic CFG_USE_BT2020   = 1'b1;

  typedef struct packed {
    logic [9:0] r;
    logic [9:0] g;
    logic [9:0] b;
  } pix_t;

  // nine signed 21-bit coefficients: y, cb, cr rows
  typedef logic signed [20:0] coef_t;
  typedef struct packed {
    coef_t yr, yg, yb, br, bg, bb, rr, rg, rb;
  } mat_t;

  localparam mat_t FULL709 = '{21'sd13933, 21'sd46871, 21'sd4732,
    -21'sd7508, -21'sd25259, 21'sd32768, 21'sd32768, -21'sd29763, -21'sd3005};
  localparam mat_t FULL2020 = '{21'sd17218, 21'sd44444, 21'sd3886,
    -21'sd9147, -21'sd23621, 21'sd32768, 21'sd32768, -21'sd30134, -21'sd2634};
  localparam mat_t LIM709_R10 = '{21'sd222927, 21'sd749942, 21'sd75707,
    -21'sd122880, -21'sd413378, 21'sd536258, 21'sd536258, -21'sd487086, -21'sd49172};
  localparam mat_t LIM709_R210 = '{21'sd217951, 21'sd733202, 21'sd74017,
    -21'sd120138, -21'sd404150, 21'sd524288, 21'sd524288, -21'sd476214, -21'sd48074};
  localparam mat_t LIM2020_R10 = '{21'sd275461, 21'sd710935, 21'sd62181,
    -21'sd149755, -21'sd386503, 21'sd536258, 21'sd536258, -21'sd493128, -21'sd43130};
  localparam mat_t LIM2020_R210 = '{21'sd269312, 21'sd695065, 21'sd60793,
    -21'sd146413, -21'sd377875, 21'sd524288, 21'sd524288, -21'sd482120, -21'sd42168};

  // (v*1023 + 2047) / 4095 via reciprocal; 4095 ≈ 2^12, quotient < 1024
  function automatic logic [9:0] scale12(input logic [11:0] v);
    logic [21:0] n;
    logic [10:0] q;
    logic [22:0] rem;
    begin
      n = 22'(v) * 22'd1023 + 22'd2047;
      // n/4095 = n/4096 * (1 + 1/4095); estimate then correct
      q = 11'((n + (n >> 12)) >> 12);
      rem = 23'(n) - 23'(q) * 23'd4095;
      if (rem[22]) q = q - 11'd1;
      else if (rem >= 23'd4095) q = q + 11'd1;
      scale12 = q[9:0];
    end
  endfunction

  // clamp signed value to 0..1023 and place into p010 word
  function automatic logic [15:0] to_p010(input logic signed [15:0] v);
    begin
      if (v < 0) to_p010 = 16'd0;
      else if (v > 16'sd1023) to_p010 = {10'h3ff, 6'd0};
      else to_p010 = {v[9:0], 6'd0};
    end
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/packed_rgb_to_p010_420_converter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// packed_rgb_to_p010_420_converter
// converts one 2x2 packed rgb quad per word into four luma, one cb and one cr sample in one word
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one quad per word: two rows of nine raw bytes each
//   m_axis carries one word per quad holding six p010 samples (four luma,
//   cb, cr)
//   cfg writes pixel_format (index 0) and use_bt2020 (index 1); write only
//   while no quad is in flight
// pipeline:
//   stage 1 unpack and 12-bit scale, stage 2 offset and chroma average,
//   stage 3 products, stage 4 sum and rounding, stage 5 clamp to output
//   one quad accepted every cycle while the output register is not stalled
// flow control:
//   all stages advance together on an enable that is high when the output
//   register is empty or being taken; a stall freezes every stage, nothing
//   is lost or repeated
// reset:
//   rst clears the valid bits and the two config registers
// ----------------------------------------------------------------------------
module packed_rgb_to_p010_420_converter (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // top_row_low_bytes[63:0], top_row_ninth_byte[71:64],
  // bottom_row_low_bytes[135:72], bottom_row_ninth_byte[143:136]
  input  wire logic [143:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
  // chroma_blue, chroma_red; 16 bits each from bit 0 up
  output logic [95:0]       m_axis_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [1:0]   cfg_data
);
  import rgb2p010_pkg::*;

  // config
  logic [1:0] pixel_format;
  logic       use_bt2020;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_R210;
      use_bt2020   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PIXEL_FORMAT: pixel_format <= cfg_data;
        CFG_USE_BT2020:   use_bt2020   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic limited;
  mat_t mat;
  assign limited = (pixel_format != FMT_C12);
  always_comb begin
    case (pixel_format)
      FMT_C12:  mat = use_bt2020 ? FULL2020 : FULL709;
      FMT_R210: mat = use_bt2020 ? LIM2020_R210 : LIM709_R210;
      default:  mat = use_bt2020 ? LIM2020_R10 : LIM709_R10;
    endcase
  end

  // shared pipeline enable
  logic [5:1] vld;
  logic       en;
  assign en = !vld[5] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[5];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[4:1], s_axis_tvalid};
  end

  // stage 1: unpack
  function automatic void unpack_row(input logic [71:0] by, input logic [1:0] fmt,
                                     output pix_t a, output pix_t b);
    logic [31:0] w0, w1;
    begin
      w0 = 32'd0;
      w1 = 32'd0;
      if (fmt == FMT_R10L) begin
        w0 = by[31:0];
        w1 = by[63:32];
      end else begin
        w0 = {by[7:0], by[15:8], by[23:16], by[31:24]};
        w1 = {by[39:32], by[47:40], by[55:48], by[63:56]};
      end
      case (fmt)
        FMT_C12: begin
          a.r = scale12({by[11:8], by[7:0]});
          a.g = scale12({by[23:16], by[15:12]});
          a.b = scale12({by[35:32], by[31:24]});
          b.r = scale12({by[47:40], by[39:36]});
          b.g = scale12({by[59:56], by[55:48]});
          b.b = scale12({by[71:64], by[63:60]});
        end
        FMT_R210: begin
          a = '{w0[29:20], w0[19:10], w0[9:0]};
          b = '{w1[29:20], w1[19:10], w1[9:0]};
        end
        default: begin
          a = '{w0[31:22], w0[21:12], w0[11:2]};
          b = '{w1[31:22], w1[21:12], w1[11:2]};
        end
      endcase
    end
  endfunction

  pix_t s1_p [4];
  pix_t u0, u1, u2, u3;
  always_comb begin
    unpack_row(s_axis_tdata[71:0], pixel_format, u0, u1);
    unpack_row(s_axis_tdata[143:72], pixel_format, u2, u3);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_p[0] <= u0; s1_p[1] <= u1; s1_p[2] <= u2; s1_p[3] <= u3;
    end
  end

  // stage 2: channel offset and quad average; index 4 holds the average
  logic signed [10:0] s2_c [5][3];
  logic [11:0] sr, sg, sb;
  logic signed [10:0] off;
  assign off = limited ? 11'sd64 : 11'sd0;
  always_comb begin
    sr = 12'(s1_p[0].r) + 12'(s1_p[1].r) + 12'(s1_p[2].r) + 12'(s1_p[3].r) + 12'd2;
    sg = 12'(s1_p[0].g) + 12'(s1_p[1].g) + 12'(s1_p[2].g) + 12'(s1_p[3].g) + 12'd2;
    sb = 12'(s1_p[0].b) + 12'(s1_p[1].b) + 12'(s1_p[2].b) + 12'(s1_p[3].b) + 12'd2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        s2_c[k][0] <= $signed({1'b0, s1_p[k].r}) - off;
        s2_c[k][1] <= $signed({1'b0, s1_p[k].g}) - off;
        s2_c[k][2] <= $signed({1'b0, s1_p[k].b}) - off;
      end
      s2_c[4][0] <= $signed({1'b0, sr[11:2]}) - off;
      s2_c[4][1] <= $signed({1'b0, sg[11:2]}) - off;
      s2_c[4][2] <= $signed({1'b0, sb[11:2]}) - off;
    end
  end

  // stage 3: products; rows 0..3 luma, 4 cb, 5 cr
  logic signed [31:0] s3_m [6][3];
  coef_t cf [6][3];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cf[k][0] = mat.yr; cf[k][1] = mat.yg; cf[k][2] = mat.yb;
    end
    cf[4][0] = mat.br; cf[4][1] = mat.bg; cf[4][2] = mat.bb;
    cf[5][0] = mat.rr; cf[5][1] = mat.rg; cf[5][2] = mat.rb;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++)
        for (int j = 0; j < 3; j++)
          s3_m[k][j] <= 32'(s2_c[(k < 4) ? k : 4][j] * cf[k][j]);
    end
  end

  // stage 4: sum and round
  logic signed [15:0] s4_v [6];
  logic signed [33:0] dsum [6];
  logic [33:0] mag [6];
  logic [33:0] rq [6];
  logic signed [15:0] rv [6];
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      dsum[k] = 34'(s3_m[k][0]) + 34'(s3_m[k][1]) + 34'(s3_m[k][2]);
      mag[k] = dsum[k][33] ? 34'(-dsum[k]) : 34'(dsum[k]);
      rq[k] = (mag[k] + 34'd524288) >> 20;
      if (limited) begin
        rv[k] = dsum[k][33] ? -16'(rq[k]) : 16'(rq[k]);
        rv[k] = rv[k] + ((k < 4) ? 16'sd64 : 16'sd512);
      end else begin
        rv[k] = 16'((dsum[k] + 34'sd32768) >>> 16) + ((k < 4) ? 16'sd0 : 16'sd512);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) for (int k = 0; k < 6; k++) s4_v[k] <= rv[k];
  end

  // stage 5: clamp into the output register
  always_ff @(posedge clk) begin
    if (en) for (int k = 0; k < 6; k++) m_axis_tdata[16*k +: 16] <= to_p010(s4_v[k]);
  end

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression for packed_rgb_to_p010_420_converter
// drives rgb quads in every packing and both matrices, predicts the p010
// words in the bench and compares each output word field by field
// ----------------------------------------------------------------------------
module tb;
  import rgb2p010_pkg::*;

  typedef struct {
    logic [63:0] top_lo;
    logic [7:0]  top_ninth;
    logic [63:0] bot_lo;
    logic [7:0]  bot_ninth;
  } quad_t;

  typedef struct {
    logic [15:0] y [4];
    logic [15:0] cb;
    logic [15:0] cr;
  } p010_t;

  typedef struct {
    longint r, g, b;
  } rgb_t;

  // directed row: optional typed-in expectation
  typedef struct {
    logic [1:0]  fmt;
    logic        bt2020;
    quad_t       q;
    logic        has_expect;
    logic [15:0] exp_luma;    // all four luma fields
    logic [15:0] exp_chroma;  // cb and cr
  } directed_row_t;

  localparam int HOLD_OFF_LEN = 300;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // top_row_low_bytes, top_row_ninth_byte, bottom_row_low_bytes,
  // bottom_row_ninth_byte
  logic [143:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // luma tl, tr, bl, br, cb, cr; 16 bits each from bit 0 up
  logic [95:0]  m_axis_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [0:0]   cfg_index = '0;
  logic [1:0]   cfg_data = '0;

  // bench copy of the config registers
  logic [1:0] fmt_q = FMT_R210;
  logic       bt2020_q = 1'b0;

  p010_t   expected_words [$];
  int      mismatches = 0;
  int      bench_errors = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_off_req = 0;
  int      hold_off_seen = 0;
  int      hold_off_cycles = 0;

  packed_rgb_to_p010_420_converter u_dut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------------
  function automatic longint rnd_q20(longint v);
    if (v >= 0) return (v + (64'sd1 << 19)) >>> 20;
    return -((-v + (64'sd1 << 19)) >>> 20);
  endfunction

  function automatic longint flr_q16(longint v);
    return v >>> 16;  // arithmetic shift is floor
  endfunction

  function automatic logic [15:0] clamp_word(longint v);
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return {v[9:0], 6'd0};
  endfunction

  function automatic longint c12_to_10(logic [11:0] v);
    return (longint'(v) * 1023 + 2047) / 4095;
  endfunction

  function automatic void unpack_pair(logic [63:0] lo, logic [7:0] ninth,
                                      logic [1:0] fmt, output rgb_t a, output rgb_t b);
    logic [7:0]  by [9];
    logic [31:0] w0, w1;
    for (int k = 0; k < 8; k++) by[k] = lo[8*k +: 8];
    by[8] = ninth;
    if (fmt == FMT_C12) begin
      a.r = c12_to_10({by[1][3:0], by[0]});
      a.g = c12_to_10({by[2], by[1][7:4]});
      a.b = c12_to_10({by[4][3:0], by[3]});
      b.r = c12_to_10({by[5], by[4][7:4]});
      b.g = c12_to_10({by[7][3:0], by[6]});
      b.b = c12_to_10({by[8], by[7][7:4]});
      return;
    end
    if (fmt == FMT_R10L) begin
      w0 = {by[3], by[2], by[1], by[0]};
      w1 = {by[7], by[6], by[5], by[4]};
    end else begin
      w0 = {by[0], by[1], by[2], by[3]};
      w1 = {by[4], by[5], by[6], by[7]};
    end
    if (fmt == FMT_R210) begin
      a.r = w0[29:20]; a.g = w0[19:10]; a.b = w0[9:0];
      b.r = w1[29:20]; b.g = w1[19:10]; b.b = w1[9:0];
    end else begin
      a.r = w0[31:22]; a.g = w0[21:12]; a.b = w0[11:2];
      b.r = w1[31:22]; b.g = w1[21:12]; b.b = w1[11:2];
    end
  endfunction

  function automatic p010_t convert_quad(quad_t q, logic [1:0] fmt, logic bt);
    p010_t  o;
    rgb_t   p [4];
    rgb_t   avg;
    longint m [9];
    logic   lim;
    lim = (fmt != FMT_C12);
    unpack_pair(q.top_lo, q.top_ninth, fmt, p[0], p[1]);
    unpack_pair(q.bot_lo, q.bot_ninth, fmt, p[2], p[3]);
    if (!lim) begin
      if (bt) m = '{17218, 44444, 3886, -9147, -23621, 32768, 32768, -30134, -2634};
      else    m = '{13933, 46871, 4732, -7508, -25259, 32768, 32768, -29763, -3005};
    end else if (fmt == FMT_R210) begin
      if (bt)
        m = '{269312, 695065, 60793, -146413, -377875, 524288, 524288, -482120, -42168};
      else
        m = '{217951, 733202, 74017, -120138, -404150, 524288, 524288, -476214, -48074};
    end else begin
      if (bt)
        m = '{275461, 710935, 62181, -149755, -386503, 536258, 536258, -493128, -43130};
      else
        m = '{222927, 749942, 75707, -122880, -413378, 536258, 536258, -487086, -49172};
    end
    for (int k = 0; k < 4; k++) begin
      if (lim)
        o.y[k] = clamp_word(64 + rnd_q20(m[0]*(p[k].r-64) + m[1]*(p[k].g-64) +
                                         m[2]*(p[k].b-64)));
      else
        o.y[k] = clamp_word(flr_q16(m[0]*p[k].r + m[1]*p[k].g + m[2]*p[k].b + 32768));
    end
    avg.r = (p[0].r + p[1].r + p[2].r + p[3].r + 2) >>> 2;
    avg.g = (p[0].g + p[1].g + p[2].g + p[3].g + 2) >>> 2;
    avg.b = (p[0].b + p[1].b + p[2].b + p[3].b + 2) >>> 2;
    if (lim) begin
      o.cb = clamp_word(512 + rnd_q20(m[3]*(avg.r-64) + m[4]*(avg.g-64) + m[5]*(avg.b-64)));
      o.cr = clamp_word(512 + rnd_q20(m[6]*(avg.r-64) + m[7]*(avg.g-64) + m[8]*(avg.b-64)));
    end else begin
      o.cb = clamp_word(flr_q16(m[3]*avg.r + m[4]*avg.g + m[5]*avg.b + 32768) + 512);
      o.cr = clamp_word(flr_q16(m[6]*avg.r + m[7]*avg.g + m[8]*avg.b + 32768) + 512);
    end
    return o;
  endfunction

  // ------------------------------------------------------------------------
  // drivers
  // ------------------------------------------------------------------------
  function automatic quad_t random_quad();
    quad_t q;
    int    mode;
    mode = $urandom_range(0, 9);
    q.top_lo = {$urandom, $urandom};
    q.bot_lo = {$urandom, $urandom};
    q.top_ninth = 8'($urandom);
    q.bot_ninth = 8'($urandom);
    // some quads saturated or flat to hit the clamps and equal-pixel corners
    if (mode == 0) begin q.top_lo = '1; q.bot_lo = '1; q.top_ninth = '1; q.bot_ninth = '1; end
    if (mode == 1) begin q.top_lo = '0; q.bot_lo = '0; end
    if (mode == 2) q.bot_lo = q.top_lo;
    return q;
  endfunction

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(logic [0:0] idx, logic [1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_PIXEL_FORMAT) fmt_q = val;
    else bt2020_q = val[0];
  endtask

  task automatic set_mode(logic [1:0] fmt, logic bt);
    write_reg(CFG_PIXEL_FORMAT, fmt);
    write_reg(CFG_USE_BT2020, {1'b0, bt});
    cfg_valid <= 1'b0;
  endtask

  // wait until every predicted quad has come out, then let the pipe settle
  task automatic drain();
    int guard;
    guard = 0;
    while (expected_words.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  // one word on the slave side; expectation queued as it is accepted
  task automatic send_quad(quad_t q);
    while (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {q.bot_ninth, q.bot_lo, q.top_ninth, q.top_lo};
    do @(posedge clk); while (!s_axis_tready);
    expected_words.push_back(convert_quad(q, fmt_q, bt2020_q));
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // receiver: random stalls plus one long hold-off
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_off_req != hold_off_seen) begin
      m_axis_tready <= 1'b0;
      hold_off_seen <= hold_off_req;
      hold_off_cycles <= HOLD_OFF_LEN - 1;
    end else if (hold_off_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      m_axis_tready <= !(recv_stall_pct != 0 && $urandom_range(1, 100) <= recv_stall_pct);
    end
  end

  // ------------------------------------------------------------------------
  // checker: compare each accepted output word with the oldest prediction
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    p010_t exp_w;
    logic [15:0] got [6];
    logic [15:0] want [6];
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      for (int k = 0; k < 6; k++) got[k] = m_axis_tdata[16*k +: 16];
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output word %h", m_axis_tdata);
      end else begin
        exp_w = expected_words.pop_front();
        want = '{exp_w.y[0], exp_w.y[1], exp_w.y[2], exp_w.y[3], exp_w.cb, exp_w.cr};
        for (int k = 0; k < 6; k++)
          if (got[k] !== want[k]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("field %0d mismatch: expected %h actual %h", k, want[k], got[k]);
          end
      end
    end
  end

  // ------------------------------------------------------------------------
  // directed table
  // ------------------------------------------------------------------------
  directed_row_t dir_rows [$];

  task automatic build_table();
    directed_row_t r;
    for (int f = 0; f < 4; f++)
      for (int bt = 0; bt < 2; bt++) begin
        r.fmt = 2'(f); r.bt2020 = 1'(bt);
        // all-zero input: below-black codes in limited range; full range gives
        // black with neutral chroma
        r.q = '{64'h0, 8'h0, 64'h0, 8'h0};
        r.has_expect = (r.fmt == FMT_C12);
        r.exp_luma = 16'h0000;
        r.exp_chroma = {10'd512, 6'd0};
        dir_rows.push_back(r);
        // all ones: full range gives white with neutral chroma
        r.q = '{'1, 8'hff, '1, 8'hff};
        r.has_expect = (r.fmt == FMT_C12);
        r.exp_luma = {10'd1023, 6'd0};
        r.exp_chroma = {10'd512, 6'd0};
        dir_rows.push_back(r);
        // mixed extremes with the unused bits set
        r.q = '{64'hc00f_fc00_3ff0_0003, 8'h5a, 64'h0ff0_f00f_ffff_0000, 8'ha5};
        r.has_expect = 1'b0;
        dir_rows.push_back(r);
      end
    // c12 with zero data: black full range is y=0, chroma at 512
    r.fmt = FMT_C12; r.bt2020 = 1'b0;
    r.q = '{64'h0, 8'h0, 64'h0, 8'h0};
    r.has_expect = 1'b1;
    r.exp_luma = 16'h0000;
    r.exp_chroma = {10'd512, 6'd0};
    dir_rows.push_back(r);
  endtask

  initial begin
    p010_t  chk;
    quad_t  q;
    int     phase_pct [4][2];
    phase_pct = '{'{0, 0}, '{53, 0}, '{0, 53}, '{38, 38}};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    build_table();
    foreach (dir_rows[i]) begin
      if (dir_rows[i].fmt != fmt_q || dir_rows[i].bt2020 != bt2020_q) begin
        end_burst();
        drain();
        set_mode(dir_rows[i].fmt, dir_rows[i].bt2020);
      end
      send_quad(dir_rows[i].q);
      // full-range black and white: every field known by eye
      if (dir_rows[i].has_expect) begin
        chk = expected_words[$];
        for (int k = 0; k < 4; k++)
          if (chk.y[k] !== dir_rows[i].exp_luma) begin
            bench_errors++;
            if (bench_errors <= 10)
              $display("row %0d luma %0d: expected %h actual %h", i, k,
                       dir_rows[i].exp_luma, chk.y[k]);
          end
        if (chk.cb !== dir_rows[i].exp_chroma || chk.cr !== dir_rows[i].exp_chroma) begin
          bench_errors++;
          if (bench_errors <= 10)
            $display("row %0d chroma: expected %h actual %h/%h", i,
                     dir_rows[i].exp_chroma, chk.cb, chk.cr);
        end
      end
    end
    end_burst();
    drain();

    // random phases: each idling profile over every packing and matrix
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = phase_pct[ph][0];
      recv_stall_pct = phase_pct[ph][1];
      for (int mode = 0; mode < 8; mode++) begin
        end_burst();
        drain();
        set_mode(mode[2:1], mode[0]);
        if (ph == 0 && mode == 3) hold_off_req <= hold_off_req + 1;
        for (int n = 0; n < 53; n++) begin
          q = random_quad();
          send_quad(q);
        end
      end
    end
    end_burst();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();

    if (expected_words.size() != 0) bench_errors++;
    if (mismatches == 0 && bench_errors == 0)
      $display("packed_rgb_to_p010_420_converter regression: pass");
    else
      $display("packed_rgb_to_p010_420_converter regression: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("packed_rgb_to_p010_420_converter regression: fail");
    $finish;
  end

endmodule
